>>> hdl/tcpop_pkg.sv
// Shared definitions for the TCP header and option parser.
// Result codes, error codes, option kinds and the result record type.
// No dependencies.
package tcpop_pkg;

  // Result kinds
  localparam logic [4:0] KIND_SRC    = 5'd0;
  localparam logic [4:0] KIND_DST    = 5'd1;
  localparam logic [4:0] KIND_SEQ    = 5'd2;
  localparam logic [4:0] KIND_ACK    = 5'd3;
  localparam logic [4:0] KIND_DOFF   = 5'd4;
  localparam logic [4:0] KIND_FLAGS  = 5'd5;
  localparam logic [4:0] KIND_WIN    = 5'd6;
  localparam logic [4:0] KIND_CSUM   = 5'd7;
  localparam logic [4:0] KIND_URG    = 5'd8;
  localparam logic [4:0] KIND_NOP    = 5'd9;
  localparam logic [4:0] KIND_MSS    = 5'd10;
  localparam logic [4:0] KIND_SCALE  = 5'd11;
  localparam logic [4:0] KIND_SACKOK = 5'd12;
  localparam logic [4:0] KIND_SACK   = 5'd13;
  localparam logic [4:0] KIND_TS     = 5'd14;
  localparam logic [4:0] KIND_END    = 5'd15;
  localparam logic [4:0] KIND_ERROR  = 5'd16;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN  = 3'd1;
  localparam logic [2:0] ERR_TRUNC    = 3'd2;
  localparam logic [2:0] ERR_BAD_DOFF = 3'd3;
  localparam logic [2:0] ERR_BAD_SACK = 3'd4;
  localparam logic [2:0] ERR_OVERRUN  = 3'd5;

  // TCP option kinds on the wire
  localparam logic [7:0] OPT_EOL    = 8'd0;
  localparam logic [7:0] OPT_NOP    = 8'd1;
  localparam logic [7:0] OPT_MSS    = 8'd2;
  localparam logic [7:0] OPT_SCALE  = 8'd3;
  localparam logic [7:0] OPT_SACKOK = 8'd4;
  localparam logic [7:0] OPT_SACK   = 8'd5;
  localparam logic [7:0] OPT_TS     = 8'd8;

  // Fixed header length and default depth of the result queue
  localparam logic [5:0] HDR_MIN_LEN   = 6'd20;
  localparam int         RES_DEPTH_DEF = 4;

  typedef struct packed {
    logic [4:0]  kind;
    logic [63:0] value;
    logic [5:0]  start;
    logic [2:0]  err;
    logic        last;
  } result_t;

endpackage

>>> hdl/tcp_header_option_parser.sv
// Top level of the TCP header and option parser.
// Depends on tcpop_pkg (codes, result_t).
//
// Usage: feed a TCP segment one byte per transaction on the in_ channel,
// header first, with in_end_of_segment high on its final byte. Each fixed
// header field, each option and the end of header come out as one
// transaction on the out_ channel; a byte causes zero, one or two results,
// and out_last_result marks the final one of that byte.
// Path: an accepted byte sits in the input register, is then written into
// the result queue and is visible on out_ once it is there.
// Throughput: one byte per cycle. The input register is processed whenever
// the result queue has room for two results; the queue drains one result
// per cycle, so sustained rate is set by the out_ side and by bytes that
// cause two results (option end plus header end, or truncation).
// Stall: when out_stall holds, the head result stays put; once the queue
// lacks room for two more, in_stall rises and the held byte waits.
// Reset (rst_n low, synchronous): queue emptied, parser at byte offset 0,
// header length 20. The byte carrying end of segment also returns the
// parser to that state after its results are produced.
module tcp_header_option_parser #(
  parameter int RES_DEPTH = tcpop_pkg::RES_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_segment_byte,
  input  logic        in_end_of_segment,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_field_kind,
  output logic [63:0] out_field_value,
  output logic [5:0]  out_field_start,
  output logic [2:0]  out_error_code,
  output logic        out_last_result
);
  import tcpop_pkg::*;

  localparam int PW = $clog2(RES_DEPTH);
  localparam logic [PW:0] CNT_LIMIT = (PW+1)'(RES_DEPTH - 2);

  // Input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_eos_r;

  // Parser state
  logic [5:0]  pos_r, pos_nxt;
  logic [5:0]  hlen_r, hlen_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [7:0]  okind_r, okind_nxt;
  logic [5:0]  oleft_r, oleft_nxt;
  logic [5:0]  ostart_r, ostart_nxt;
  logic        ostop_r, ostop_nxt;
  logic        hdone_r, hdone_nxt;

  // Result queue
  result_t        fifo_r [RES_DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [PW:0]    cnt_r;

  logic    proc, pop;
  result_t res_a, res_e, res_t, slot0, slot1;
  logic    a_v, e_v, t_v;
  logic [1:0] n_res;

  // Process the held byte only when the queue can take two results.
  assign proc     = in_vld_r && (cnt_r <= CNT_LIMIT);
  assign in_stall = in_vld_r && !proc;
  assign pop      = (cnt_r != '0) && !out_stall;

  always_comb begin
    logic [7:0]  b;
    logic [63:0] acc_sh;
    logic [3:0]  doff;
    logic [3:0]  size;
    logic        sized;
    logic [5:0]  off;
    logic        emit;

    b      = in_byte_r;
    acc_sh = {acc_r[55:0], b};
    doff   = b[7:4];
    size   = 4'd0;
    sized  = 1'b0;
    off    = pos_r - ostart_r;
    emit   = 1'b0;

    pos_nxt    = pos_r;
    hlen_nxt   = hlen_r;
    acc_nxt    = acc_r;
    okind_nxt  = okind_r;
    oleft_nxt  = oleft_r;
    ostart_nxt = ostart_r;
    ostop_nxt  = ostop_r;
    hdone_nxt  = hdone_r;

    a_v   = 1'b0;
    e_v   = 1'b0;
    t_v   = 1'b0;
    res_a = '{kind: KIND_SRC, value: '0, start: '0, err: ERR_NONE, last: 1'b0};
    res_e = res_a;
    res_t = res_a;

    if (!hdone_r) begin
      if (pos_r < HDR_MIN_LEN) begin
        // fixed header: shift bytes in, report on the closing byte
        acc_nxt = acc_sh;
        case (pos_r)
          6'd1: begin
            a_v = 1'b1; res_a.kind = KIND_SRC; res_a.value = {48'd0, acc_sh[15:0]};
            res_a.start = 6'd0; acc_nxt = '0;
          end
          6'd3: begin
            a_v = 1'b1; res_a.kind = KIND_DST; res_a.value = {48'd0, acc_sh[15:0]};
            res_a.start = 6'd2; acc_nxt = '0;
          end
          6'd7: begin
            a_v = 1'b1; res_a.kind = KIND_SEQ; res_a.value = {32'd0, acc_sh[31:0]};
            res_a.start = 6'd4; acc_nxt = '0;
          end
          6'd11: begin
            a_v = 1'b1; res_a.kind = KIND_ACK; res_a.value = {32'd0, acc_sh[31:0]};
            res_a.start = 6'd8; acc_nxt = '0;
          end
          6'd12: begin
            a_v = 1'b1; res_a.kind = KIND_DOFF; res_a.value = {60'd0, doff};
            res_a.start = 6'd12;
            res_a.err   = (doff < 4'd5) ? ERR_BAD_DOFF : ERR_NONE;
            hlen_nxt    = (doff < 4'd5) ? HDR_MIN_LEN : {doff, 2'b00};
            acc_nxt     = {63'd0, b[0]};   // NS flag
          end
          6'd13: begin
            a_v = 1'b1; res_a.kind = KIND_FLAGS; res_a.value = {55'd0, acc_sh[8:0]};
            res_a.start = 6'd12; acc_nxt = '0;
          end
          6'd15: begin
            a_v = 1'b1; res_a.kind = KIND_WIN; res_a.value = {48'd0, acc_sh[15:0]};
            res_a.start = 6'd14; acc_nxt = '0;
          end
          6'd17: begin
            a_v = 1'b1; res_a.kind = KIND_CSUM; res_a.value = {48'd0, acc_sh[15:0]};
            res_a.start = 6'd16; acc_nxt = '0;
          end
          6'd19: begin
            a_v = 1'b1; res_a.kind = KIND_URG; res_a.value = {48'd0, acc_sh[15:0]};
            res_a.start = 6'd18; acc_nxt = '0;
          end
          default: ;
        endcase
      end else if (!ostop_r) begin
        if (oleft_r == '0) begin
          // kind byte of a new option
          case (b)
            OPT_EOL:    ostop_nxt = 1'b1;
            OPT_NOP: begin
              a_v = 1'b1; res_a.kind = KIND_NOP; res_a.start = pos_r;
            end
            OPT_MSS:    begin size = 4'd4;  sized = 1'b1; end
            OPT_SCALE:  begin size = 4'd3;  sized = 1'b1; end
            OPT_SACKOK: begin size = 4'd2;  sized = 1'b1; end
            OPT_SACK:   begin size = 4'd2;  sized = 1'b1; end
            OPT_TS:     begin size = 4'd10; sized = 1'b1; end
            default: begin
              ostop_nxt = 1'b1;
              a_v = 1'b1; res_a.kind = KIND_ERROR; res_a.value = {56'd0, b};
              res_a.start = pos_r; res_a.err = ERR_UNKNOWN;
            end
          endcase
          if (sized) begin
            if (({1'b0, pos_r} + {3'd0, size}) > {1'b0, hlen_r}) begin
              ostop_nxt = 1'b1;
              a_v = 1'b1; res_a.kind = KIND_ERROR; res_a.value = {56'd0, b};
              res_a.start = pos_r; res_a.err = ERR_OVERRUN;
            end else begin
              okind_nxt  = b;
              ostart_nxt = pos_r;
              oleft_nxt  = {2'd0, size} - 6'd1;
              acc_nxt    = '0;
            end
          end
        end else begin
          // body byte of the current option
          oleft_nxt = oleft_r - 6'd1;
          emit = 1'b1;
          if (okind_r == OPT_SACK && off == 6'd1) begin
            if (b < 8'd2) begin
              ostop_nxt = 1'b1; oleft_nxt = '0; emit = 1'b0;
              a_v = 1'b1; res_a.kind = KIND_ERROR; res_a.value = {56'd0, b};
              res_a.start = ostart_r; res_a.err = ERR_BAD_SACK;
            end else if (({3'd0, ostart_r} + {1'b0, b}) > {3'd0, hlen_r}) begin
              ostop_nxt = 1'b1; oleft_nxt = '0; emit = 1'b0;
              a_v = 1'b1; res_a.kind = KIND_ERROR; res_a.value = {56'd0, okind_r};
              res_a.start = ostart_r; res_a.err = ERR_OVERRUN;
            end else begin
              acc_nxt   = {56'd0, b};
              oleft_nxt = 6'(b - 8'd2);
            end
          end else if (okind_r != OPT_SACK && off >= 6'd2) begin
            acc_nxt = acc_sh;
          end
          if (emit && oleft_nxt == '0) begin
            a_v = 1'b1; res_a.start = ostart_r;
            case (okind_r)
              OPT_MSS:    begin res_a.kind = KIND_MSS;   res_a.value = {48'd0, acc_nxt[15:0]}; end
              OPT_SCALE:  begin res_a.kind = KIND_SCALE; res_a.value = {56'd0, acc_nxt[7:0]}; end
              OPT_SACKOK: begin res_a.kind = KIND_SACKOK; res_a.value = 64'd1; end
              OPT_SACK:   begin res_a.kind = KIND_SACK;  res_a.value = acc_nxt; end
              default:    begin res_a.kind = KIND_TS;    res_a.value = acc_nxt; end
            endcase
          end
        end
      end

      // header complete?
      if (({1'b0, pos_r} + 7'd1) >= {1'b0, hlen_nxt}) begin
        e_v = 1'b1; res_e.kind = KIND_END; res_e.value = {58'd0, hlen_nxt};
        res_e.start = hlen_nxt;
        hdone_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + 6'd1;
      end

      if (in_eos_r && !hdone_nxt) begin
        t_v = 1'b1; res_t.kind = KIND_ERROR;
        res_t.value = {57'd0, ({1'b0, pos_r} + 7'd1)};
        res_t.start = pos_r; res_t.err = ERR_TRUNC;
      end
    end

    if (in_eos_r) begin
      pos_nxt    = '0;
      hlen_nxt   = HDR_MIN_LEN;
      acc_nxt    = '0;
      okind_nxt  = '0;
      oleft_nxt  = '0;
      ostart_nxt = '0;
      ostop_nxt  = 1'b0;
      hdone_nxt  = 1'b0;
    end

    // pack the (at most two) results in order
    slot0 = a_v ? res_a : (e_v ? res_e : res_t);
    slot1 = (a_v && e_v) ? res_e : res_t;
    n_res = 2'({1'b0, a_v} + {1'b0, e_v} + {1'b0, t_v});
    slot0.last = (n_res == 2'd1);
    slot1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      pos_r    <= '0;
      hlen_r   <= HDR_MIN_LEN;
      acc_r    <= '0;
      okind_r  <= '0;
      oleft_r  <= '0;
      ostart_r <= '0;
      ostop_r  <= 1'b0;
      hdone_r  <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (proc) begin
        pos_r    <= pos_nxt;
        hlen_r   <= hlen_nxt;
        acc_r    <= acc_nxt;
        okind_r  <= okind_nxt;
        oleft_r  <= oleft_nxt;
        ostart_r <= ostart_nxt;
        ostop_r  <= ostop_nxt;
        hdone_r  <= hdone_nxt;
        wr_ptr_r <= wr_ptr_r + PW'(n_res);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      cnt_r <= cnt_r + (proc ? (PW+1)'(n_res) : '0) - (pop ? (PW+1)'(1) : '0);
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_segment_byte;
      in_eos_r  <= in_end_of_segment;
    end
    if (proc && n_res != 2'd0) begin
      fifo_r[wr_ptr_r] <= slot0;
    end
    if (proc && n_res == 2'd2) begin
      fifo_r[wr_ptr_r + PW'(1)] <= slot1;
    end
  end

  assign out_valid       = (cnt_r != '0);
  assign out_field_kind  = fifo_r[rd_ptr_r].kind;
  assign out_field_value = fifo_r[rd_ptr_r].value;
  assign out_field_start = fifo_r[rd_ptr_r].start;
  assign out_error_code  = fifo_r[rd_ptr_r].err;
  assign out_last_result = fifo_r[rd_ptr_r].last;

  // queue never overfills
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(RES_DEPTH))
    else $error("result queue overfilled");

  // header length is 20..60 and a multiple of four
  a_hlen_ok: assert property (@(posedge clk) disable iff (!rst_n)
    hlen_r >= HDR_MIN_LEN && hlen_r[1:0] == 2'b00)
    else $error("header length out of range");

  // once done, the position sits on the last header byte
  a_done_pos: assert property (@(posedge clk) disable iff (!rst_n)
    hdone_r |-> (({1'b0, pos_r} + 7'd1) >= {1'b0, hlen_r}))
    else $error("header done before its end");

  // a held byte is processed in the cycle the queue frees enough room
  a_proc_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && cnt_r <= CNT_LIMIT) |=> (cnt_r != '0 || $past(n_res) == 2'd0))
    else $error("processed byte lost its results");

endmodule

>>> verif/tcp_header_option_parser_tb.sv
// Self-checking testbench for tcp_header_option_parser.
// A byte-level predictor of the TCP header and option walk checks every result field.
// Depends on tcpop_pkg and the parser RTL.
module tcp_header_option_parser_tb;
  import tcpop_pkg::*;

  // One stimulus row: a segment byte, its end-of-segment mark and, for a few
  // directed rows, the single result typed in by hand instead of predicted.
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    logic       typed;
    result_t    want;
  } seg_row_t;

  localparam result_t NO_FIELD = '0;
  localparam int      RANDOM_BYTES = 1550;
  localparam int      CALM_TAIL = 150;  // final transactions sent with no idling

  // Directed part: a short truncated segment, a one-byte segment, then a
  // 20-byte header, all ones up to the window, with a data offset below 5.
  localparam seg_row_t DIRECTED [24] = '{
    '{8'hFF, 1'b0, 1'b0, NO_FIELD},
    '{8'hFF, 1'b0, 1'b1, '{KIND_SRC, 64'hFFFF, 6'd0, ERR_NONE, 1'b1}},
    '{8'h00, 1'b1, 1'b1, '{KIND_ERROR, 64'd3, 6'd2, ERR_TRUNC, 1'b1}},
    '{8'h00, 1'b1, 1'b1, '{KIND_ERROR, 64'd1, 6'd0, ERR_TRUNC, 1'b1}},
    '{8'hFF, 1'b0, 1'b0, NO_FIELD},
    '{8'hFF, 1'b0, 1'b1, '{KIND_SRC, 64'hFFFF, 6'd0, ERR_NONE, 1'b1}},
    '{8'hFF, 1'b0, 1'b0, NO_FIELD},
    '{8'hFF, 1'b0, 1'b1, '{KIND_DST, 64'hFFFF, 6'd2, ERR_NONE, 1'b1}},
    '{8'hFF, 1'b0, 1'b0, NO_FIELD},
    '{8'hFF, 1'b0, 1'b0, NO_FIELD},
    '{8'hFF, 1'b0, 1'b0, NO_FIELD},
    '{8'hFF, 1'b0, 1'b1, '{KIND_SEQ, 64'hFFFF_FFFF, 6'd4, ERR_NONE, 1'b1}},
    '{8'hFF, 1'b0, 1'b0, NO_FIELD},
    '{8'hFF, 1'b0, 1'b0, NO_FIELD},
    '{8'hFF, 1'b0, 1'b0, NO_FIELD},
    '{8'hFF, 1'b0, 1'b1, '{KIND_ACK, 64'hFFFF_FFFF, 6'd8, ERR_NONE, 1'b1}},
    '{8'h4F, 1'b0, 1'b1, '{KIND_DOFF, 64'd4, 6'd12, ERR_BAD_DOFF, 1'b1}},
    '{8'hFF, 1'b0, 1'b1, '{KIND_FLAGS, 64'h1FF, 6'd12, ERR_NONE, 1'b1}},
    '{8'hFF, 1'b0, 1'b0, NO_FIELD},
    '{8'hFF, 1'b0, 1'b1, '{KIND_WIN, 64'hFFFF, 6'd14, ERR_NONE, 1'b1}},
    '{8'h00, 1'b0, 1'b0, NO_FIELD},
    '{8'h00, 1'b0, 1'b1, '{KIND_CSUM, 64'd0, 6'd16, ERR_NONE, 1'b1}},
    '{8'h00, 1'b0, 1'b0, NO_FIELD},
    '{8'h00, 1'b1, 1'b0, NO_FIELD}   // urgent pointer plus header end
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_segment_byte = 8'd0;
  logic        in_end_of_segment = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  out_field_kind;
  logic [63:0] out_field_value;
  logic [5:0]  out_field_start;
  logic [2:0]  out_error_code;
  logic        out_last_result;

  tcp_header_option_parser dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_segment_byte   (in_segment_byte),
    .in_end_of_segment (in_end_of_segment),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_field_kind    (out_field_kind),
    .out_field_value   (out_field_value),
    .out_field_start   (out_field_start),
    .out_error_code    (out_error_code),
    .out_last_result   (out_last_result)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Parser predictor: its own copy of the byte walk state
  // ---------------------------------------------------------------------
  logic [5:0]  rx_pos;        // header byte offset of the next byte
  logic [5:0]  hdr_len;       // 20, or data offset * 4 once byte 12 is seen
  logic [63:0] field_acc;     // shift register for multi-byte fields
  logic [7:0]  opt_kind;
  logic [5:0]  opt_left;      // bytes still owed to the current option
  logic [5:0]  opt_start;
  logic        opts_halted;   // EOL or an option error ends the walk
  logic        hdr_complete;  // header end reported, rest is payload

  result_t byte_fields[$];    // results of the byte just decoded
  result_t fields_due[$];     // expected results, oldest first

  function automatic void clear_parser();
    rx_pos       = 6'd0;
    hdr_len      = HDR_MIN_LEN;
    field_acc    = 64'd0;
    opt_kind     = 8'd0;
    opt_left     = 6'd0;
    opt_start    = 6'd0;
    opts_halted  = 1'b0;
    hdr_complete = 1'b0;
  endfunction

  function automatic void note(input logic [4:0] kind, input logic [63:0] value,
                               input logic [5:0] start, input logic [2:0] err);
    byte_fields.push_back('{kind, value, start, err, 1'b0});
  endfunction

  // One byte inside the option area
  function automatic void walk_option(input logic [5:0] p, input logic [7:0] b);
    logic [7:0] size;
    logic [5:0] off;
    logic       stop;
    size = 8'd0;
    stop = 1'b0;
    if (opt_left == 6'd0) begin
      // kind byte: fixed sizes, sack starts at its minimum of 2
      case (b)
        OPT_EOL:    opts_halted = 1'b1;
        OPT_NOP:    note(KIND_NOP, 64'd0, p, ERR_NONE);
        OPT_MSS:    size = 8'd4;
        OPT_SCALE:  size = 8'd3;
        OPT_SACKOK: size = 8'd2;
        OPT_SACK:   size = 8'd2;
        OPT_TS:     size = 8'd10;
        default: begin
          opts_halted = 1'b1;
          note(KIND_ERROR, {56'd0, b}, p, ERR_UNKNOWN);
        end
      endcase
      if (size != 8'd0) begin
        if ({2'b00, p} + size > {2'b00, hdr_len}) begin
          opts_halted = 1'b1;
          note(KIND_ERROR, {56'd0, b}, p, ERR_OVERRUN);
        end else begin
          opt_kind  = b;
          opt_start = p;
          opt_left  = 6'(size - 8'd1);
          field_acc = 64'd0;
        end
      end
    end else begin
      off      = p - opt_start;
      opt_left = opt_left - 6'd1;
      if (opt_kind == OPT_SACK && off == 6'd1) begin
        // sack length byte decides the real size
        if (b < 8'd2) begin
          opts_halted = 1'b1;
          opt_left    = 6'd0;
          stop        = 1'b1;
          note(KIND_ERROR, {56'd0, b}, opt_start, ERR_BAD_SACK);
        end else if ({3'b000, opt_start} + {1'b0, b} > {3'b000, hdr_len}) begin
          opts_halted = 1'b1;
          opt_left    = 6'd0;
          stop        = 1'b1;
          note(KIND_ERROR, {56'd0, opt_kind}, opt_start, ERR_OVERRUN);
        end else begin
          field_acc = {56'd0, b};
          opt_left  = 6'(b - 8'd2);
        end
      end else if (opt_kind != OPT_SACK && off >= 6'd2) begin
        // length byte of fixed options is skipped, data shifts in
        field_acc = {field_acc[55:0], b};
      end
      if (!stop && opt_left == 6'd0) begin
        case (opt_kind)
          OPT_MSS:    note(KIND_MSS, {48'd0, field_acc[15:0]}, opt_start, ERR_NONE);
          OPT_SCALE:  note(KIND_SCALE, {56'd0, field_acc[7:0]}, opt_start, ERR_NONE);
          OPT_SACKOK: note(KIND_SACKOK, 64'd1, opt_start, ERR_NONE);
          OPT_SACK:   note(KIND_SACK, field_acc, opt_start, ERR_NONE);
          default:    note(KIND_TS, field_acc, opt_start, ERR_NONE);
        endcase
      end
    end
  endfunction

  // Decode one accepted segment byte into byte_fields
  function automatic void decode_segment_byte(input logic [7:0] b, input logic eos);
    logic [5:0] p;
    logic [3:0] doff;
    byte_fields.delete();
    if (!hdr_complete) begin
      p = rx_pos;
      if (p < 6'd20) begin
        field_acc = {field_acc[55:0], b};
        case (p)
          6'd1: begin
            note(KIND_SRC, {48'd0, field_acc[15:0]}, 6'd0, ERR_NONE);
            field_acc = 64'd0;
          end
          6'd3: begin
            note(KIND_DST, {48'd0, field_acc[15:0]}, 6'd2, ERR_NONE);
            field_acc = 64'd0;
          end
          6'd7: begin
            note(KIND_SEQ, {32'd0, field_acc[31:0]}, 6'd4, ERR_NONE);
            field_acc = 64'd0;
          end
          6'd11: begin
            note(KIND_ACK, {32'd0, field_acc[31:0]}, 6'd8, ERR_NONE);
            field_acc = 64'd0;
          end
          6'd12: begin
            // data offset; NS bit stays in the accumulator for the flags
            doff = b[7:4];
            note(KIND_DOFF, {60'd0, doff}, 6'd12,
                 (doff < 4'd5) ? ERR_BAD_DOFF : ERR_NONE);
            hdr_len   = (doff < 4'd5) ? HDR_MIN_LEN : {doff, 2'b00};
            field_acc = {63'd0, b[0]};
          end
          6'd13: begin
            note(KIND_FLAGS, {55'd0, field_acc[8:0]}, 6'd12, ERR_NONE);
            field_acc = 64'd0;
          end
          6'd15: begin
            note(KIND_WIN, {48'd0, field_acc[15:0]}, 6'd14, ERR_NONE);
            field_acc = 64'd0;
          end
          6'd17: begin
            note(KIND_CSUM, {48'd0, field_acc[15:0]}, 6'd16, ERR_NONE);
            field_acc = 64'd0;
          end
          6'd19: begin
            note(KIND_URG, {48'd0, field_acc[15:0]}, 6'd18, ERR_NONE);
            field_acc = 64'd0;
          end
          default: ;
        endcase
      end else if (!opts_halted) begin
        walk_option(p, b);
      end
      if ({1'b0, p} + 7'd1 >= {1'b0, hdr_len}) begin
        note(KIND_END, {58'd0, hdr_len}, hdr_len, ERR_NONE);
        hdr_complete = 1'b1;
      end else begin
        rx_pos = p + 6'd1;
      end
      // segment ended inside the header
      if (eos && !hdr_complete)
        note(KIND_ERROR, {58'd0, p} + 64'd1, p, ERR_TRUNC);
    end
    if (eos)
      clear_parser();
    if (byte_fields.size() > 0)
      byte_fields[byte_fields.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus: directed rows, then random segments
  // ---------------------------------------------------------------------
  seg_row_t segment_bytes[$];

  // Mostly well-formed headers with a random option mix; a share of stray
  // bytes, bad sack lengths, overruns, bad data offsets, cut-short segments
  // and pure noise segments.
  function automatic void add_random_segment();
    logic [7:0] seg[$];
    int pick, r, len, doff, hl, cut;
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 30)) seg.push_back(8'($urandom));
    end else begin
      repeat (12) seg.push_back(8'($urandom));
      doff = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 15);
      seg.push_back({doff[3:0], 4'($urandom)});
      repeat (7) seg.push_back(8'($urandom));
      hl = (doff < 5) ? 20 : doff * 4;
      while (seg.size() < hl) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          seg.push_back(8'($urandom));
        end else if (pick < 22) begin
          seg.push_back(OPT_NOP);
        end else if (pick < 34) begin
          seg.push_back(OPT_MSS);
          seg.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'd4);
          repeat (2) seg.push_back(8'($urandom));
        end else if (pick < 44) begin
          seg.push_back(OPT_SCALE);
          seg.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'd3);
          seg.push_back(8'($urandom));
        end else if (pick < 52) begin
          seg.push_back(OPT_SACKOK);
          seg.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'd2);
        end else if (pick < 66) begin
          seg.push_back(OPT_TS);
          seg.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'd10);
          repeat (8) seg.push_back(8'($urandom));
        end else if (pick < 82) begin
          r = $urandom_range(0, 9);
          if (r == 0)
            len = $urandom_range(0, 1);
          else if (r == 1)
            len = $urandom_range(2, 255);
          else
            len = 2 + 8 * $urandom_range(0, 3);
          seg.push_back(OPT_SACK);
          seg.push_back(8'(len));
          repeat ((len > 2) ? len - 2 : 0) seg.push_back(8'($urandom));
        end else if (pick < 90) begin
          // end of list, padding zeros or junk
          seg.push_back(OPT_EOL);
          r = $urandom_range(0, 1);
          while (seg.size() < hl) seg.push_back((r == 0) ? 8'd0 : 8'($urandom));
        end else begin
          r = $urandom_range(6, 255);
          if (r == 8)
            r = 7;
          seg.push_back(8'(r));
        end
      end
      while (seg.size() > hl) void'(seg.pop_back());
      repeat ($urandom_range(0, 6)) seg.push_back(8'($urandom));
    end
    cut = seg.size();
    if ($urandom_range(0, 6) == 0)
      cut = $urandom_range(1, seg.size());
    for (int i = 0; i < cut; i++)
      segment_bytes.push_back('{seg[i], (i == cut - 1), 1'b0, NO_FIELD});
  endfunction

  // ---------------------------------------------------------------------
  // Driver, idling and result checker share one clocked process so that
  // expectations are queued before the same edge samples any result.
  // ---------------------------------------------------------------------
  seg_row_t on_bus;
  result_t  want;
  int       next_row = 0;
  int       sent_cnt = 0;
  int       gap_left = 0;
  int       stall_left = 0;
  int       fail_cnt = 0;
  logic     calm;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      calm = (next_row + CALM_TAIL >= segment_bytes.size());

      // input transaction completes: predict its results
      if (in_valid && !in_stall) begin
        decode_segment_byte(in_segment_byte, in_end_of_segment);
        if (on_bus.typed)
          fields_due.push_back(on_bus.want);
        else
          foreach (byte_fields[i]) fields_due.push_back(byte_fields[i]);
        sent_cnt++;
        if (!calm && $urandom_range(0, 4) == 0)
          gap_left = $urandom_range(1, 3);
      end

      // a stalled byte holds; otherwise idle or present the next row
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (next_row < segment_bytes.size()) begin
          on_bus = segment_bytes[next_row];
          next_row++;
          in_valid          <= 1'b1;
          in_segment_byte   <= on_bus.data;
          in_end_of_segment <= on_bus.eos;
        end else begin
          in_valid <= 1'b0;
        end
      end

      // output transaction: compare with the oldest expectation
      if (out_valid && !out_stall) begin
        if (fields_due.size() == 0) begin
          $error("unexpected result: kind %0d value %h", out_field_kind, out_field_value);
          fail_cnt++;
        end else begin
          want = fields_due.pop_front();
          if (out_field_kind !== want.kind) begin
            $error("field_kind: expected %0d, got %0d", want.kind, out_field_kind);
            fail_cnt++;
          end
          if (out_field_value !== want.value) begin
            $error("field_value: expected %h, got %h", want.value, out_field_value);
            fail_cnt++;
          end
          if (out_field_start !== want.start) begin
            $error("field_start: expected %0d, got %0d", want.start, out_field_start);
            fail_cnt++;
          end
          if (out_error_code !== want.err) begin
            $error("error_code: expected %0d, got %0d", want.err, out_error_code);
            fail_cnt++;
          end
          if (out_last_result !== want.last) begin
            $error("last_result: expected %0d, got %0d", want.last, out_last_result);
            fail_cnt++;
          end
        end
      end

      // receiver stalls in random bursts, none during the calm tail
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------
  initial begin
    clear_parser();
    foreach (DIRECTED[i]) segment_bytes.push_back(DIRECTED[i]);
    while (segment_bytes.size() < $size(DIRECTED) + RANDOM_BYTES)
      add_random_segment();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (!(sent_cnt == segment_bytes.size() && fields_due.size() == 0))
      @(posedge clk);
    // wait on so that any stray result is caught
    repeat (10) @(posedge clk);
    if (fail_cnt == 0)
      $display("tcp_header_option_parser regression: pass");
    else
      $display("tcp_header_option_parser regression: fail");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #400000;
    $display("tcp_header_option_parser regression: fail");
    $finish;
  end

endmodule
